/* rtl/core/sttok_pkg.sv */
// Shared types, character codes and token helpers for the source text tokenizer.
// No dependencies; imported by sttok_step and source_text_tokenizer_core.
package sttok_pkg;

    // Position counter width; the reported position has the same width, and the counter saturates at POS_MAX
    localparam int POS_W     = 16;
    localparam int LEN_W     = 16;
    localparam int MAX_NEST  = 8;
    localparam int DEPTH_W   = $clog2(MAX_NEST + 1);
    localparam int STK_IW    = $clog2(MAX_NEST);
    // One result slot per open comment covers the end-of-text flush
    localparam int BATCH     = MAX_NEST;
    localparam int BIDX_W    = $clog2(BATCH);
    localparam int BCNT_W    = $clog2(BATCH + 1);

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PIPE  = 8'h7C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [3:0] {
        K_END    = 4'd0,
        K_PLUS   = 4'd1,
        K_MINUS  = 4'd2,
        K_STAR   = 4'd3,
        K_PIPE   = 4'd4,
        K_SLASH  = 4'd5,
        K_STRING = 4'd6,
        K_NUMBER = 4'd7,
        K_ERROR  = 4'd8
    } t_kind;

    typedef enum logic [1:0] {
        E_NONE    = 2'd0,
        E_INVALID = 2'd1,
        E_UNTERM  = 2'd2,
        E_DEEP    = 2'd3
    } t_err;

    typedef enum logic [2:0] {
        M_NORMAL = 3'd0,
        M_SLASH  = 3'd1,
        M_LINE   = 3'd2,
        M_BLOCK  = 3'd3,
        M_BSLASH = 3'd4,
        M_BSTAR  = 3'd5,
        M_STRING = 3'd6,
        M_NUMBER = 3'd7
    } t_mode;

    typedef struct packed {
        t_kind             kind;
        t_err              err;
        logic [POS_W-1:0]  pos;
        logic [LEN_W-1:0]  len;
        logic [7:0]        bad;
    } t_tok;

    typedef struct packed {
        t_mode               mode;
        logic [DEPTH_W-1:0]  depth;
        logic [POS_W-1:0]    cnt;
        logic [POS_W-1:0]    start;
        logic [LEN_W-1:0]    len;
        logic                dec;
        logic                prev_end;
    } t_state;

    typedef struct packed {
        logic               en;
        logic [STK_IW-1:0]  idx;
        logic [POS_W-1:0]   val;
    } t_push;

    localparam t_state ST_RESET = '{
        mode:     M_NORMAL,
        depth:    '0,
        cnt:      '0,
        start:    '0,
        len:      '0,
        dec:      1'b0,
        prev_end: 1'b0
    };

    function automatic t_tok mk_tok(t_kind k, t_err e, logic [POS_W-1:0] p,
                                    logic [LEN_W-1:0] l, logic [7:0] b);
        t_tok t;
        t.kind = k;
        t.err  = e;
        t.pos  = p;
        t.len  = l;
        t.bad  = b;
        return t;
    endfunction

endpackage

/* rtl/core/sttok_step.sv */
// Next-state and token logic for one tokenizer step (one byte or end of text).
// Depends on sttok_pkg; instantiated by source_text_tokenizer_core.
module sttok_step
    import sttok_pkg::*;
(
    input  t_state       i_st,
    input  logic [7:0]   i_char,
    input  logic         i_end,
    output t_state       o_st,
    output t_tok         o_tok0,
    output t_tok         o_tok1,
    output logic [1:0]   o_ntok,
    output logic         o_flush,
    output t_push        o_push
);

    typedef struct packed {
        logic   emit;
        t_mode  mode;
        t_tok   tok;
    } t_scan;

    localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);

    // Scan a byte in normal mode: start a multi-byte token, emit a single one, or emit nothing
    function automatic t_scan scan(logic [7:0] c, logic [POS_W-1:0] p, logic prev);
        t_scan s;
        s.emit = 1'b0;
        s.mode = M_NORMAL;
        s.tok  = mk_tok(K_END, E_NONE, p, LEN_ONE, 8'd0);
        unique case (c)
            CH_SPACE, CH_TAB: ;
            CH_NL, CH_SEMI: s.emit = !prev;
            CH_PLUS:  begin s.emit = 1'b1; s.tok.kind = K_PLUS;  end
            CH_MINUS: begin s.emit = 1'b1; s.tok.kind = K_MINUS; end
            CH_STAR:  begin s.emit = 1'b1; s.tok.kind = K_STAR;  end
            CH_PIPE:  begin s.emit = 1'b1; s.tok.kind = K_PIPE;  end
            CH_SLASH: s.mode = M_SLASH;
            CH_QUOTE: s.mode = M_STRING;
            default: begin
                if (c >= CH_ZERO && c <= CH_NINE) begin
                    s.mode = M_NUMBER;
                end else begin
                    s.emit = 1'b1;
                    s.tok  = mk_tok(K_ERROR, E_INVALID, p, LEN_ONE, c);
                end
            end
        endcase
        return s;
    endfunction

    t_scan             sc;
    logic [POS_W-1:0]  pos;
    logic [LEN_W-1:0]  len_inc;
    logic [DEPTH_W-1:0] depth_dec;
    logic              use_scan;
    logic              scan_second;
    logic              is_digit;

    always_comb begin
        pos       = (i_st.cnt == POS_MAX) ? i_st.cnt : i_st.cnt + POS_W'(1);
        len_inc   = (i_st.len == LEN_MAX) ? i_st.len : i_st.len + LEN_ONE;
        depth_dec = (i_st.depth != '0) ? i_st.depth - DEPTH_W'(1) : i_st.depth;
        is_digit  = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
        // a token emitted ahead of the scan always clears the end-of-statement flag
        sc        = scan(i_char, pos, (i_st.mode == M_NORMAL) ? i_st.prev_end : 1'b0);

        o_st        = i_st;
        o_tok0      = mk_tok(K_END, E_NONE, i_st.start, LEN_ONE, 8'd0);
        o_tok1      = sc.tok;
        o_ntok      = 2'd0;
        o_flush     = 1'b0;
        o_push      = '{en: 1'b0, idx: i_st.depth[STK_IW-1:0], val: i_st.start};
        use_scan    = 1'b0;
        scan_second = 1'b0;

        if (i_end) begin
            unique case (i_st.mode)
                M_SLASH: begin
                    o_tok0.kind = K_SLASH;
                    o_ntok      = 2'd1;
                end
                M_STRING: begin
                    o_tok0.kind = K_ERROR;
                    o_tok0.err  = E_UNTERM;
                    o_ntok      = 2'd1;
                end
                M_NUMBER: begin
                    o_tok0.kind = K_NUMBER;
                    o_tok0.len  = i_st.len;
                    o_ntok      = 2'd1;
                end
                M_BLOCK, M_BSLASH, M_BSTAR: o_flush = 1'b1;
                M_NORMAL, M_LINE: ;
            endcase
            o_st = ST_RESET;
        end else begin
            o_st.cnt = pos;
            unique case (i_st.mode)
                M_NORMAL: use_scan = 1'b1;
                M_SLASH: begin
                    if (i_char == CH_SLASH) begin
                        o_st.mode = M_LINE;
                    end else if (i_char == CH_STAR) begin
                        o_st.mode  = M_BLOCK;
                        o_st.depth = DEPTH_W'(1);
                        o_push     = '{en: 1'b1, idx: '0, val: i_st.start};
                    end else begin
                        o_tok0.kind = K_SLASH;
                        o_ntok      = 2'd1;
                        use_scan    = 1'b1;
                        scan_second = 1'b1;
                    end
                end
                M_LINE: begin
                    if (i_char == CH_NL) o_st.mode = M_NORMAL;
                end
                M_BLOCK: begin
                    if (i_char == CH_SLASH) begin
                        o_st.mode  = M_BSLASH;
                        o_st.start = pos;
                    end else if (i_char == CH_STAR) begin
                        o_st.mode = M_BSTAR;
                    end
                end
                M_BSLASH: begin
                    if (i_char == CH_STAR) begin
                        if (i_st.depth < DEPTH_W'(MAX_NEST)) begin
                            o_push.en  = 1'b1;
                            o_st.depth = i_st.depth + DEPTH_W'(1);
                        end else begin
                            o_tok0.kind = K_ERROR;
                            o_tok0.err  = E_DEEP;
                            o_ntok      = 2'd1;
                        end
                        o_st.mode = M_BLOCK;
                    end else if (i_char == CH_SLASH) begin
                        o_st.start = pos;
                    end else begin
                        o_st.mode = M_BLOCK;
                    end
                end
                M_BSTAR: begin
                    if (i_char == CH_SLASH) begin
                        o_st.depth = depth_dec;
                        o_st.mode  = (depth_dec == '0) ? M_NORMAL : M_BLOCK;
                    end else if (i_char != CH_STAR) begin
                        o_st.mode = M_BLOCK;
                    end
                end
                M_STRING: begin
                    if (i_char == CH_QUOTE) begin
                        o_tok0.kind = K_STRING;
                        o_tok0.len  = i_st.len;
                        o_ntok      = 2'd1;
                        o_st.mode   = M_NORMAL;
                    end else if (i_char == CH_NL) begin
                        o_tok0.kind = K_ERROR;
                        o_tok0.err  = E_UNTERM;
                        o_ntok      = 2'd1;
                        o_st.mode   = M_NORMAL;
                    end else begin
                        o_st.len = len_inc;
                    end
                end
                M_NUMBER: begin
                    if (is_digit) begin
                        o_st.len = len_inc;
                    end else if (i_char == CH_DOT && !i_st.dec) begin
                        o_st.dec = 1'b1;
                        o_st.len = len_inc;
                    end else begin
                        o_tok0.kind = K_NUMBER;
                        o_tok0.len  = i_st.len;
                        o_ntok      = 2'd1;
                        use_scan    = 1'b1;
                        scan_second = 1'b1;
                    end
                end
            endcase

            if (use_scan) begin
                o_st.mode = sc.mode;
                unique case (sc.mode)
                    M_SLASH: o_st.start = pos;
                    M_STRING: begin
                        o_st.start = pos;
                        o_st.len   = '0;
                    end
                    M_NUMBER: begin
                        o_st.start = pos;
                        o_st.len   = LEN_ONE;
                        o_st.dec   = 1'b0;
                    end
                    default: ;
                endcase
                if (sc.emit) begin
                    if (scan_second) begin
                        o_ntok = 2'd2;
                    end else begin
                        o_tok0 = sc.tok;
                        o_ntok = 2'd1;
                    end
                end
            end

            // the flag follows the last token emitted
            if (o_ntok == 2'd2) begin
                o_st.prev_end = (o_tok1.kind == K_END);
            end else if (o_ntok == 2'd1) begin
                o_st.prev_end = (o_tok0.kind == K_END);
            end
        end
    end

endmodule

/* rtl/core/source_text_tokenizer_core.sv */
// Streaming source tokenizer: one byte or end-of-text marker in, tokens out.
// Depends on sttok_pkg and sttok_step.
//
// One byte is taken per cycle into an input register while o_stall is low;
// the step logic updates the lexer state and loads the tokens that byte
// completes into a registered result buffer that drives the output port.
// Bytes that complete no token or one token run at one per cycle while the
// output is not stalled. A byte that completes two tokens, or an end-of-text
// marker that closes several open comments (one result per open comment),
// keeps the output busy until all its results are delivered, since the output
// port delivers one token per cycle when not stalled; the next byte with
// results waits in the input register until the last of them is being taken.
// A stall on the output holds the result buffer and, once a byte with
// results is waiting, the input.
module source_text_tokenizer_core
    import sttok_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [7:0]          i_char_in,
    input  logic                i_end_of_text,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [3:0]          o_token_kind,
    output logic [1:0]          o_error_kind,
    output logic [15:0]         o_position,
    output logic [15:0]         o_lexeme_length,
    output logic [7:0]          o_bad_char,
    output logic                o_last
);

    logic               r_v;
    logic [7:0]         r_char;
    logic               r_end;
    t_state             r_st;
    t_state             n_st;
    logic [POS_W-1:0]   r_stack [MAX_NEST];
    t_tok               r_slot [BATCH];
    t_tok               n_slot [BATCH];
    logic [BCNT_W-1:0]  r_cnt;
    logic [BIDX_W-1:0]  r_idx;

    t_tok               tok0;
    t_tok               tok1;
    logic [1:0]         ntok;
    logic               flush;
    t_push              push;
    logic [BCNT_W-1:0]  n_res;
    logic               batch_free;
    logic               adv;
    logic               out_xfer;
    t_tok               cur;

    sttok_step u_step (
        .i_st    (r_st),
        .i_char  (r_char),
        .i_end   (r_end),
        .o_st    (n_st),
        .o_tok0  (tok0),
        .o_tok1  (tok1),
        .o_ntok  (ntok),
        .o_flush (flush),
        .o_push  (push)
    );

    always_comb begin
        n_res      = flush ? BCNT_W'(r_st.depth) : BCNT_W'(ntok);
        out_xfer   = o_valid && !i_stall;
        batch_free = (r_cnt == '0) || ((r_cnt == BCNT_W'(1)) && !i_stall);
        // a byte with no results never waits on the output
        adv        = r_v && ((n_res == '0) || batch_free);
        o_stall    = r_v && !adv;

        for (int i = 0; i < BATCH; i++) begin
            if (flush) begin
                n_slot[i] = mk_tok(K_ERROR, E_UNTERM, r_stack[i], LEN_W'(1), 8'd0);
            end else if (i == 0) begin
                n_slot[i] = tok0;
            end else begin
                n_slot[i] = tok1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v   <= 1'b0;
            r_st  <= ST_RESET;
            r_cnt <= '0;
            r_idx <= '0;
        end else begin
            if (!o_stall) r_v <= i_valid;
            if (adv) r_st <= n_st;
            if (adv && (n_res != '0)) begin
                r_cnt <= n_res;
                r_idx <= '0;
            end else if (out_xfer) begin
                r_cnt <= r_cnt - BCNT_W'(1);
                r_idx <= r_idx + BIDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_char <= i_char_in;
            r_end  <= i_end_of_text;
        end
        if (adv && push.en) r_stack[push.idx] <= push.val;
        if (adv && (n_res != '0)) begin
            for (int i = 0; i < BATCH; i++) r_slot[i] <= n_slot[i];
        end
    end

    assign cur             = r_slot[r_idx];
    assign o_valid         = (r_cnt != '0);
    assign o_last          = (r_cnt == BCNT_W'(1));
    assign o_token_kind    = cur.kind;
    assign o_error_kind    = cur.err;
    assign o_position      = cur.pos;
    assign o_lexeme_length = cur.len;
    assign o_bad_char      = cur.bad;

`ifndef NO_ASSERTIONS
    a_depth_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.depth <= DEPTH_W'(MAX_NEST))
        else $error("comment depth above limit");

    a_block_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.mode == M_BLOCK || r_st.mode == M_BSLASH || r_st.mode == M_BSTAR)
        |-> r_st.depth != '0)
        else $error("block comment mode with no open comment");

    a_batch_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last) |=> o_valid)
        else $error("result batch ended before its last transaction");

    a_pos_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_position != '0)
        else $error("token position is zero");
`endif

endmodule
